FILE: rtl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// Used by text_console_cursor_engine_top; no other dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

  // Fixed field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // Default geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // Operation codes
  localparam logic [2:0] KIND_PUT   = 3'd0;
  localparam logic [2:0] KIND_MOVE  = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_FILL  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BLANK = 8'h20;

  // Register indexes
  localparam logic CFG_TEXT_ATTR   = 1'b0;
  localparam logic CFG_RESERVE_ROW = 1'b1;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        char_code;
    logic signed [7:0] target_row;
    logic signed [7:0] target_col;
    logic [7:0]        cell_attr;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_word_t;

  function automatic logic [CELL_W-1:0] blank_cell(input logic [7:0] attr);
    return {attr, CH_BLANK};
  endfunction

endpackage

FILE: rtl/text_console_cursor_engine_top.sv
// Text console cursor engine: cell memory, cursor and operation sequencer.
// Depends on tcce_pkg for the word types, codes and widths.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid, in_stall | in_word  (operation word)
//  out     | output    | out_valid,out_stall| out_word (cursor, cell, scroll)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Every accepted operation passes S_EXEC, S_POS and S_OUT; an in-range read adds
// S_READ, a fill whose row is in range adds S_FILL over that row, a clear S_FILL over
// all ROWS*COLUMNS cells, and a scroll S_SCROLL to move the usable rows up, all set by the
// one memory write port at a cell a cycle. After reset the memory is swept to blanks
// with in_stall high; config writes are taken throughout. A result waits in the
// output register; a stalled output holds the sequencer at a second one.

module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + COLUMNS);
  localparam int TABS  = 1 << COL_W;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_SCROLL = 8'b0010_0000,
    S_POS    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t            state;
  in_word_t          item;
  logic [7:0]        text_attr;
  logic              reserve_last_row;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  // shared position unit operands
  logic [ROW_W-1:0]  mul_row;
  logic [COL_W-1:0]  mul_col;
  logic [AW-1:0]     pos;

  // sweep sequencer
  logic [SW-1:0]     sweep;
  logic [SW-1:0]     sweep_end;
  logic [SW-1:0]     src_d;
  logic [SW-1:0]     lim_cells;
  logic              wr_pend;
  logic [CELL_W-1:0] fill_val;

  // cell memory
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic [7:0]        tab_stop [TABS];
  logic [5:0]        usable;
  logic [ROW_W-1:0]  bs_row;
  logic [COL_W-1:0]  bs_col;
  logic [5:0]        pc_row;
  logic [7:0]        pc_col;
  logic              pc_scroll;
  logic              row_ok;
  logic              in_rng;
  logic [ROW_W-1:0]  mv_row;
  logic [COL_W-1:0]  mv_col;
  logic              in_take;

  // next tab stop for each column, worked out at elaboration
  for (genvar g = 0; g < TABS; g++) begin : g_tab
    assign tab_stop[g] = 8'((g / TAB_WIDTH + 1) * TAB_WIDTH);
  end

  assign usable   = reserve_last_row ? 6'(ROWS - 1) : 6'(ROWS);
  assign pos      = AW'(int'(mul_row) * COLUMNS + int'(mul_col));
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // target range checks on the latched word
  assign row_ok = !item.target_row[7] && ({1'b0, item.target_row[6:0]} < 8'(ROWS));
  assign in_rng = row_ok && !item.target_col[7] &&
                  ({1'b0, item.target_col[6:0]} < 8'(COLUMNS));

  // backspace step from the current cursor
  always_comb begin
    bs_row = cur_row;
    bs_col = cur_col;
    if (cur_col != '0) begin
      bs_col = cur_col - 1'b1;
    end else if (cur_row != '0) begin
      bs_row = cur_row - 1'b1;
      bs_col = COL_W'(COLUMNS - 1);
    end
  end

  // put char cursor update, wrap and scroll decision
  always_comb begin
    pc_row = {1'b0, cur_row};
    pc_col = {1'b0, cur_col};
    case (item.char_code)
      CH_CR: begin
        pc_col = '0;
      end
      CH_LF: begin
        pc_col = '0;
        pc_row = pc_row + 1'b1;
      end
      CH_BS: begin
        pc_row = {1'b0, bs_row};
        pc_col = {1'b0, bs_col};
      end
      CH_TAB: begin
        pc_col = tab_stop[cur_col];
      end
      default: begin
        pc_col = pc_col + 1'b1;
      end
    endcase
    if (pc_col >= 8'(COLUMNS)) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end
    pc_scroll = (pc_row >= usable);
  end

  // move cursor clamping
  always_comb begin
    if (item.target_row[7]) begin
      mv_row = '0;
    end else if ({1'b0, item.target_row[6:0]} >= {2'b00, usable}) begin
      mv_row = ROW_W'(usable - 1'b1);
    end else begin
      mv_row = item.target_row[ROW_W-1:0];
    end
    if (item.target_col[7]) begin
      mv_col = '0;
    end else if ({1'b0, item.target_col[6:0]} >= 8'(COLUMNS)) begin
      mv_col = COL_W'(COLUMNS - 1);
    end else begin
      mv_col = item.target_col[COL_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep[AW-1:0];
    mem_wdata = fill_val;
    mem_raddr = pos;
    case (state)
      S_INIT, S_FILL: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        mem_waddr = pos;
        if (item.kind == KIND_PUT && item.char_code != CH_CR &&
            item.char_code != CH_LF && item.char_code != CH_TAB) begin
          mem_we    = 1'b1;
          mem_wdata = (item.char_code == CH_BS) ? blank_cell(text_attr)
                                                : {text_attr, item.char_code};
        end else if (item.kind == KIND_WRITE && in_rng) begin
          mem_we    = 1'b1;
          mem_wdata = {item.cell_attr, item.char_code};
        end
      end
      S_SCROLL: begin
        mem_raddr = sweep[AW-1:0];
        mem_we    = wr_pend;
        mem_waddr = AW'(src_d - SW'(COLUMNS));
        mem_wdata = (src_d < lim_cells) ? rd_data : fill_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr        <= ATTR_RESET;
      reserve_last_row <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_ATTR:   text_attr        <= cfg_data;
        CFG_RESERVE_ROW: reserve_last_row <= cfg_data[0];
        default:         text_attr        <= text_attr;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_word.cursor_row <= cur_row;
      out_word.cursor_col <= cur_col;
      out_word.cursor_pos <= POS_W'(pos);
      out_word.cell_data  <= cell_data;
      out_word.scrolled   <= scrolled;
    end
  end

  // sequencer and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cur_row   <= '0;
      cur_col   <= '0;
      sweep     <= '0;
      sweep_end <= SW'(CELLS - 1);
      fill_val  <= blank_cell(ATTR_RESET);
      wr_pend   <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == sweep_end) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            item      <= in_word;
            cell_data <= '0;
            scrolled  <= 1'b0;
            state     <= S_EXEC;
            if (in_word.kind == KIND_PUT) begin
              mul_row <= (in_word.char_code == CH_BS) ? bs_row : cur_row;
              mul_col <= (in_word.char_code == CH_BS) ? bs_col : cur_col;
            end else begin
              mul_row <= in_word.target_row[ROW_W-1:0];
              mul_col <= (in_word.kind == KIND_FILL) ? '0
                                                     : in_word.target_col[COL_W-1:0];
            end
          end
        end
        S_EXEC: begin
          state <= S_POS;
          case (item.kind)
            KIND_PUT: begin
              if (pc_scroll) begin
                scrolled  <= 1'b1;
                cur_row   <= ROW_W'(usable - 1'b1);
                cur_col   <= '0;
                fill_val  <= blank_cell(text_attr);
                lim_cells <= reserve_last_row ? SW'(CELLS - COLUMNS) : SW'(CELLS);
                sweep_end <= reserve_last_row ? SW'(CELLS - 1) : SW'(CELLS + COLUMNS - 1);
                sweep     <= SW'(COLUMNS);
                wr_pend   <= 1'b0;
                state     <= S_SCROLL;
              end else begin
                cur_row <= pc_row[ROW_W-1:0];
                cur_col <= pc_col[COL_W-1:0];
              end
            end
            KIND_MOVE: begin
              cur_row <= mv_row;
              cur_col <= mv_col;
            end
            KIND_CLEAR: begin
              cur_row   <= '0;
              cur_col   <= '0;
              fill_val  <= blank_cell(text_attr);
              sweep     <= '0;
              sweep_end <= SW'(CELLS - 1);
              state     <= S_FILL;
            end
            KIND_FILL: begin
              if (row_ok) begin
                fill_val  <= blank_cell(item.cell_attr);
                sweep     <= SW'(pos);
                sweep_end <= SW'(pos) + SW'(COLUMNS - 1);
                state     <= S_FILL;
              end
            end
            KIND_READ: begin
              if (in_rng) begin
                state <= S_READ;
              end
            end
            default: begin
              state <= S_POS;
            end
          endcase
        end
        S_READ: begin
          cell_data <= rd_data;
          state     <= S_POS;
        end
        S_FILL: begin
          sweep <= sweep + 1'b1;
          if (sweep == sweep_end) begin
            state <= S_POS;
          end
        end
        S_SCROLL: begin
          // read one cell ahead, write it one row up on the next cycle
          if (sweep <= sweep_end) begin
            src_d   <= sweep;
            wr_pend <= 1'b1;
            sweep   <= sweep + 1'b1;
          end else begin
            wr_pend <= 1'b0;
          end
          if (wr_pend && src_d == sweep_end) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          mul_row <= cur_row;
          mul_col <= cur_col;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
